@@ rtl/core/mrfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter request frame builder package
// Shared types, frame constants and the binary to BCD helper.
// ----------------------------------------------------------------------------
package mrfb_pkg;

  // Largest number of wake-up bytes that a frame may carry.
  localparam int unsigned MAX_PREAMBLE = 4;

  // Frame kinds.
  localparam logic CMD_READ      = 1'b0;
  localparam logic CMD_TIME_SYNC = 1'b1;

  // Fixed frame bytes.
  localparam logic [7:0] WAKE_BYTE      = 8'hFE;
  localparam logic [7:0] FRAME_HEAD     = 8'h68;
  localparam logic [7:0] CTRL_READ      = 8'h11;
  localparam logic [7:0] LEN_READ       = 8'h04;
  localparam logic [7:0] DATA_OFFSET    = 8'h33;
  localparam logic [7:0] FRAME_END      = 8'h16;
  localparam logic [7:0] BCAST_ADDR     = 8'h99;
  localparam logic [7:0] CTRL_TIME_SYNC = 8'h08;
  localparam logic [7:0] LEN_TIME_SYNC  = 8'h06;

  // Byte offsets inside the checksummed body (first 0x68 is offset zero).
  localparam logic [3:0] BODY_HEAD1     = 4'd0;
  localparam logic [3:0] BODY_ADDR0     = 4'd1;
  localparam logic [3:0] BODY_ADDR5     = 4'd6;
  localparam logic [3:0] BODY_HEAD2     = 4'd7;
  localparam logic [3:0] BODY_CTRL      = 4'd8;
  localparam logic [3:0] BODY_LEN       = 4'd9;
  localparam logic [3:0] BODY_DATA0     = 4'd10;
  localparam logic [3:0] BODY_LAST_READ = 4'd13;
  localparam logic [3:0] BODY_LAST_SYNC = 4'd15;

  // Queue depth between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One input beat.
  typedef struct packed {
    logic       cmd;
    logic [2:0] preamble_count;
    logic [31:0] data_id;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [6:0] year_offset;
  } request_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } result_t;

  // Classified request as the back end consumes it.
  typedef struct packed {
    logic            cmd;
    logic [2:0]      preamble;
    logic [31:0]     data_id;
    logic [5:0][7:0] time_bcd;
  } job_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRE  = 5'b00010,
    ST_BODY = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_END  = 5'b10000
  } back_state_t;

  // Binary to BCD for values below 128; tens by reciprocal multiply.
  // The result wraps at eight bits, so 127 becomes 0xC7.
  function automatic logic [7:0] to_bcd(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod     = 15'(x) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    ones     = x - tens_x10;
    return {tens, 4'b0000} + 8'(ones);
  endfunction

endpackage

@@ rtl/core/mrfb_front.sv @@
// ----------------------------------------------------------------------------
// Meter request frame builder front end
// Accepts requests, clamps the preamble and converts the time fields to BCD.
// ----------------------------------------------------------------------------
module mrfb_front (
  input  logic                   start,
  input  mrfb_pkg::request_t     request,
  input  mrfb_pkg::queue_status_t qstat,
  output logic                   push,
  output mrfb_pkg::job_t         job
);

  logic [2:0] pre_clamped;

  // A beat is taken whenever the queue has room.
  assign push = start && !qstat.full;

  // Long preambles saturate at the limit.
  assign pre_clamped = (request.preamble_count > 3'(mrfb_pkg::MAX_PREAMBLE))
                       ? 3'(mrfb_pkg::MAX_PREAMBLE) : request.preamble_count;

  // Build the job; time fields go out seconds first.
  always_comb begin
    job.cmd         = request.cmd;
    job.preamble    = pre_clamped;
    job.data_id     = request.data_id;
    job.time_bcd[0] = mrfb_pkg::to_bcd(7'(request.second));
    job.time_bcd[1] = mrfb_pkg::to_bcd(7'(request.minute));
    job.time_bcd[2] = mrfb_pkg::to_bcd(7'(request.hour));
    job.time_bcd[3] = mrfb_pkg::to_bcd(7'(request.day_of_month));
    job.time_bcd[4] = mrfb_pkg::to_bcd(7'(request.month));
    job.time_bcd[5] = mrfb_pkg::to_bcd(request.year_offset);
  end

endmodule

@@ rtl/core/mrfb_queue.sv @@
// ----------------------------------------------------------------------------
// Meter request frame builder job queue
// Two-entry queue that decouples request intake from frame transmission.
// ----------------------------------------------------------------------------
module mrfb_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mrfb_pkg::job_t          push_job,
  input  logic                    pop,
  output mrfb_pkg::job_t          head_job,
  output mrfb_pkg::queue_status_t qstat
);

  mrfb_pkg::job_t entries [mrfb_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head_job    = entries[rd_ptr];
  assign qstat.full  = (count == 2'(mrfb_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == 2'd0);

  // Checks.
  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("queue push while full");
  ap_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("queue pop while empty");
  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(mrfb_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ rtl/core/mrfb_back.sv @@
// ----------------------------------------------------------------------------
// Meter request frame builder back end
// Sequences one queued job into frame bytes, one beat per cycle.
// ----------------------------------------------------------------------------
module mrfb_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [47:0]             slave_address,
  input  mrfb_pkg::job_t          head_job,
  input  mrfb_pkg::queue_status_t qstat,
  output logic                    pop,
  output logic                    result_strobe,
  output mrfb_pkg::result_t       result
);

  mrfb_pkg::back_state_t state;
  mrfb_pkg::job_t        held;
  logic [2:0]            pre_left;
  logic [3:0]            body_idx;
  logic [7:0]            checksum_sum;
  logic [7:0]            body_byte;
  logic [7:0]            out_byte;
  logic [3:0]            body_last;
  logic [2:0]            addr_sel;
  logic [2:0]            data_sel;
  logic [7:0]            addr_byte;
  logic [7:0]            data_byte;

  // A new job is loaded when idle or while the closing byte goes out.
  assign pop = !qstat.empty && (state == mrfb_pkg::ST_IDLE || state == mrfb_pkg::ST_END);

  assign body_last = (held.cmd == mrfb_pkg::CMD_TIME_SYNC)
                     ? mrfb_pkg::BODY_LAST_SYNC : mrfb_pkg::BODY_LAST_READ;

  // Address and data byte selection.
  assign addr_sel  = 3'(body_idx - mrfb_pkg::BODY_ADDR0);
  assign data_sel  = 3'(body_idx - mrfb_pkg::BODY_DATA0);
  assign addr_byte = (held.cmd == mrfb_pkg::CMD_TIME_SYNC)
                     ? mrfb_pkg::BCAST_ADDR : slave_address[8*addr_sel +: 8];
  assign data_byte = (held.cmd == mrfb_pkg::CMD_TIME_SYNC)
                     ? held.time_bcd[data_sel]
                     : held.data_id[8*data_sel[1:0] +: 8] + mrfb_pkg::DATA_OFFSET;

  // Checksummed body byte at the current offset.
  always_comb begin
    case (body_idx) inside
      mrfb_pkg::BODY_HEAD1, mrfb_pkg::BODY_HEAD2: body_byte = mrfb_pkg::FRAME_HEAD;
      [mrfb_pkg::BODY_ADDR0 : mrfb_pkg::BODY_ADDR5]: body_byte = addr_byte;
      mrfb_pkg::BODY_CTRL: body_byte = (held.cmd == mrfb_pkg::CMD_TIME_SYNC)
                                       ? mrfb_pkg::CTRL_TIME_SYNC : mrfb_pkg::CTRL_READ;
      mrfb_pkg::BODY_LEN: body_byte = (held.cmd == mrfb_pkg::CMD_TIME_SYNC)
                                      ? mrfb_pkg::LEN_TIME_SYNC : mrfb_pkg::LEN_READ;
      default: body_byte = data_byte;
    endcase
  end

  // Byte leaving in the current state.
  always_comb begin
    unique case (state)
      mrfb_pkg::ST_IDLE: out_byte = mrfb_pkg::FRAME_END;
      mrfb_pkg::ST_PRE:  out_byte = mrfb_pkg::WAKE_BYTE;
      mrfb_pkg::ST_BODY: out_byte = body_byte;
      mrfb_pkg::ST_SUM:  out_byte = checksum_sum;
      mrfb_pkg::ST_END:  out_byte = mrfb_pkg::FRAME_END;
      default:           out_byte = mrfb_pkg::FRAME_END;
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mrfb_pkg::ST_IDLE;
      pre_left      <= 3'd0;
      body_idx      <= 4'd0;
      checksum_sum  <= 8'd0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state != mrfb_pkg::ST_IDLE);
      unique case (state)
        mrfb_pkg::ST_PRE: begin
          pre_left <= pre_left - 3'd1;
          if (pre_left == 3'd1) begin
            state <= mrfb_pkg::ST_BODY;
          end
        end
        mrfb_pkg::ST_BODY: begin
          checksum_sum <= checksum_sum + body_byte;
          body_idx     <= body_idx + 4'd1;
          if (body_idx == body_last) begin
            state <= mrfb_pkg::ST_SUM;
          end
        end
        mrfb_pkg::ST_SUM: begin
          state <= mrfb_pkg::ST_END;
        end
        mrfb_pkg::ST_IDLE, mrfb_pkg::ST_END: begin
          if (pop) begin
            pre_left     <= head_job.preamble;
            body_idx     <= 4'd0;
            checksum_sum <= 8'd0;
            state        <= (head_job.preamble != 3'd0) ? mrfb_pkg::ST_PRE
                                                       : mrfb_pkg::ST_BODY;
          end else begin
            state <= mrfb_pkg::ST_IDLE;
          end
        end
        default: state <= mrfb_pkg::ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head_job;
    end
    result.frame_byte <= out_byte;
    result.last       <= (state == mrfb_pkg::ST_END);
  end

  // Checks.
  ap_last_is_end: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last |-> result.frame_byte == mrfb_pkg::FRAME_END)
    else $error("last beat is not the end byte");
  ap_body_bound: assert property (@(posedge clk) disable iff (rst)
    state == mrfb_pkg::ST_BODY |-> body_idx <= body_last)
    else $error("body offset past frame end");
  ap_pre_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == mrfb_pkg::ST_PRE |-> pre_left != 3'd0)
    else $error("preamble state with nothing left");
  ap_sum_then_end: assert property (@(posedge clk) disable iff (rst)
    state == mrfb_pkg::ST_SUM |=> state == mrfb_pkg::ST_END)
    else $error("checksum byte not followed by end byte");

endmodule

@@ rtl/core/meter_request_frame_builder.sv @@
// ----------------------------------------------------------------------------
// Meter request frame builder
// Turns read and time sync requests into outgoing meter frames, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the beat is taken at a
//   clock edge where start is high and busy is low. busy is high only while
//   the two-entry job queue is full.
//   Result channel: each frame byte appears on result for one cycle with
//   result_strobe high; result.last marks the closing 0x16 byte. The
//   receiver cannot stall, so bytes leave at one per cycle without a gap.
//   Configuration: slave_address_we writes slave_address_wdata into the
//   meter address; write it only while no frame is queued or in flight.
//   Start of a frame: when the sequencer is free, a taken request is written
//   into the queue, loaded into the sequencer, and its first byte is registered.
//   Frame size: a read frame is preamble + 16 bytes and a time sync frame
//   preamble + 18 bytes (at most 22), sent by the byte sequencer at one byte
//   per cycle; queued frames follow back to back.
//   Reset clears the queue, the sequencer and the address (to zero).
// ----------------------------------------------------------------------------
module meter_request_frame_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mrfb_pkg::request_t  request,
  input  logic                slave_address_we,
  input  logic [47:0]         slave_address_wdata,
  output logic                result_strobe,
  output mrfb_pkg::result_t   result
);

  logic                    push;
  logic                    pop;
  mrfb_pkg::job_t          push_job;
  mrfb_pkg::job_t          head_job;
  mrfb_pkg::queue_status_t qstat;
  logic [47:0]             slave_address;

  // Meter address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 48'd0;
    end else if (slave_address_we) begin
      slave_address <= slave_address_wdata;
    end
  end

  assign busy = qstat.full;

  // Request intake and classification.
  mrfb_front u_front (
    .start   (start),
    .request (request),
    .qstat   (qstat),
    .push    (push),
    .job     (push_job)
  );

  // Job queue.
  mrfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  // Frame byte sequencer.
  mrfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .head_job      (head_job),
    .qstat         (qstat),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

@@ tb/meter_request_frame_builder_test.sv @@
// ----------------------------------------------------------------------------
// Meter request frame builder testbench
// Sends read and time sync requests under several meter addresses, predicts
// every byte of each outgoing frame and compares it with the bytes the block
// emits, including the checksum and the end-of-frame marker.
// ----------------------------------------------------------------------------
module meter_request_frame_builder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned PHASE_ITEMS    = 50;
  localparam int unsigned MAX_REPORTS    = 10;

  // Holds the frame bytes still owed by the block and checks each one.
  class frame_byte_checker;
    logic [47:0]       meter_addr;
    mrfb_pkg::result_t owed_bytes[$];
    int unsigned       mismatches;

    function new();
      meter_addr = '0;
      mismatches = 0;
    endfunction

    function void set_address(logic [47:0] addr);
      meter_addr = addr;
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    // Binary to packed BCD, wrapping at eight bits.
    function logic [7:0] bcd_byte(logic [6:0] v);
      int unsigned x;
      x = v;
      return 8'(((x / 10) << 4) + (x % 10));
    endfunction

    // Builds the whole frame for one accepted request beat.
    function void note_request(mrfb_pkg::request_t r);
      logic [7:0]  body[$];
      logic [7:0]  sum;
      int unsigned wake;
      wake = (r.preamble_count > mrfb_pkg::MAX_PREAMBLE) ? mrfb_pkg::MAX_PREAMBLE
                                                         : r.preamble_count;
      repeat (wake) owed_bytes.push_back(mrfb_pkg::result_t'{mrfb_pkg::WAKE_BYTE, 1'b0});
      body.push_back(mrfb_pkg::FRAME_HEAD);
      for (int i = 0; i < 6; i++) begin
        body.push_back((r.cmd == mrfb_pkg::CMD_TIME_SYNC) ? mrfb_pkg::BCAST_ADDR
                                                          : meter_addr[8*i +: 8]);
      end
      body.push_back(mrfb_pkg::FRAME_HEAD);
      if (r.cmd == mrfb_pkg::CMD_READ) begin
        body.push_back(mrfb_pkg::CTRL_READ);
        body.push_back(mrfb_pkg::LEN_READ);
        for (int i = 0; i < 4; i++) begin
          body.push_back(8'(r.data_id[8*i +: 8] + mrfb_pkg::DATA_OFFSET));
        end
      end else begin
        body.push_back(mrfb_pkg::CTRL_TIME_SYNC);
        body.push_back(mrfb_pkg::LEN_TIME_SYNC);
        body.push_back(bcd_byte(7'(r.second)));
        body.push_back(bcd_byte(7'(r.minute)));
        body.push_back(bcd_byte(7'(r.hour)));
        body.push_back(bcd_byte(7'(r.day_of_month)));
        body.push_back(bcd_byte(7'(r.month)));
        body.push_back(bcd_byte(r.year_offset));
      end
      // The checksum covers the body only, not the wake-up bytes.
      sum = '0;
      foreach (body[i]) begin
        sum = 8'(sum + body[i]);
        owed_bytes.push_back(mrfb_pkg::result_t'{body[i], 1'b0});
      end
      owed_bytes.push_back(mrfb_pkg::result_t'{sum, 1'b0});
      owed_bytes.push_back(mrfb_pkg::result_t'{mrfb_pkg::FRAME_END, 1'b1});
    endfunction

    // Compares one emitted beat with the oldest owed byte.
    function void check_byte(mrfb_pkg::result_t got);
      mrfb_pkg::result_t exp;
      if (owed_bytes.size() == 0) begin
        flag($sformatf("unexpected beat: frame_byte=%02h last=%0b",
                       got.frame_byte, got.last));
        return;
      end
      exp = owed_bytes.pop_front();
      if (got.frame_byte !== exp.frame_byte || got.last !== exp.last) begin
        flag($sformatf("beat mismatch: frame_byte exp %02h got %02h, last exp %0b got %0b",
                       exp.frame_byte, got.frame_byte, exp.last, got.last));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  mrfb_pkg::request_t request = '0;
  logic               slave_address_we = 1'b0;
  logic [47:0]        slave_address_wdata = '0;
  logic               result_strobe;
  mrfb_pkg::result_t  result;

  frame_byte_checker frame_check = new();
  int unsigned       quiet_cycles = 0;

  meter_request_frame_builder dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .request             (request),
    .slave_address_we    (slave_address_we),
    .slave_address_wdata (slave_address_wdata),
    .result_strobe       (result_strobe),
    .result              (result)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: note accepted requests, check emitted bytes, guard against hangs.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) begin
        frame_check.note_request(request);
      end
      if (result_strobe) begin
        frame_check.check_byte(result);
      end
      if ((start && !busy) || result_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic mrfb_pkg::request_t make_request(logic cmd, logic [2:0] pre,
                                                      logic [31:0] di,
                                                      logic [5:0] sec, logic [5:0] mnt,
                                                      logic [4:0] hr, logic [4:0] day,
                                                      logic [3:0] mon, logic [6:0] yr);
    mrfb_pkg::request_t r;
    r.cmd            = cmd;
    r.preamble_count = pre;
    r.data_id        = di;
    r.second         = sec;
    r.minute         = mnt;
    r.hour           = hr;
    r.day_of_month   = day;
    r.month          = mon;
    r.year_offset    = yr;
    return r;
  endfunction

  // Presents one request beat, optionally after a random idle burst.
  task automatic send_request(input mrfb_pkg::request_t r, input bit allow_idle);
    int unsigned gap;
    gap = 0;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  // Drains all frames, lets the block settle, then writes the meter address.
  task automatic write_address(input logic [47:0] addr);
    start <= 1'b0;
    do @(posedge clk); while (frame_check.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    slave_address_we    <= 1'b1;
    slave_address_wdata <= addr;
    @(posedge clk);
    slave_address_we <= 1'b0;
    frame_check.set_address(addr);
  endtask

  // Random requests; time fields mostly in range, sometimes full width.
  task automatic run_phase(input logic [47:0] addr, input bit allow_idle);
    mrfb_pkg::request_t r;
    bit                 wide;
    write_address(addr);
    repeat (PHASE_ITEMS) begin
      wide             = ($urandom_range(0, 4) == 0);
      r.cmd            = $urandom_range(0, 1) ? mrfb_pkg::CMD_TIME_SYNC : mrfb_pkg::CMD_READ;
      r.preamble_count = 3'($urandom_range(0, 7));
      r.data_id        = $urandom;
      r.second         = 6'(wide ? $urandom_range(0, 63) : $urandom_range(0, 59));
      r.minute         = 6'(wide ? $urandom_range(0, 63) : $urandom_range(0, 59));
      r.hour           = 5'(wide ? $urandom_range(0, 31) : $urandom_range(0, 23));
      r.day_of_month   = 5'(wide ? $urandom_range(0, 31) : $urandom_range(1, 31));
      r.month          = 4'(wide ? $urandom_range(0, 15) : $urandom_range(1, 12));
      r.year_offset    = 7'(wide ? $urandom_range(0, 127) : $urandom_range(0, 99));
      send_request(r, allow_idle);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames, sent back to back so the job queue fills up.
    write_address(48'hA5C3_0F96_7E81);
    send_request(make_request(mrfb_pkg::CMD_READ, 3'd0, 32'h0000_0000, 6'd0, 6'd0,
                              5'd0, 5'd1, 4'd1, 7'd0), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_READ, 3'd4, 32'hFFFF_FFFF, 6'd0, 6'd0,
                              5'd0, 5'd1, 4'd1, 7'd0), 1'b0);
    // A long preamble saturates; data bytes wrap when the offset is added.
    send_request(make_request(mrfb_pkg::CMD_READ, 3'd7, 32'hCDCD_CDCD, 6'd0, 6'd0,
                              5'd0, 5'd1, 4'd1, 7'd0), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_READ, 3'd5, 32'h1234_5678, 6'd0, 6'd0,
                              5'd0, 5'd1, 4'd1, 7'd0), 1'b0);
    // Time fields must not leak into a read request.
    send_request(make_request(mrfb_pkg::CMD_READ, 3'd2, 32'h0102_0304, 6'd63, 6'd63,
                              5'd31, 5'd31, 4'd15, 7'd127), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_TIME_SYNC, 3'd0, 32'h0000_0000, 6'd0, 6'd0,
                              5'd0, 5'd1, 4'd1, 7'd0), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_TIME_SYNC, 3'd4, 32'h0000_0000, 6'd59, 6'd59,
                              5'd23, 5'd31, 4'd12, 7'd99), 1'b0);
    // Out-of-range time fields still convert digit by digit.
    send_request(make_request(mrfb_pkg::CMD_TIME_SYNC, 3'd7, 32'hFFFF_FFFF, 6'd63, 6'd63,
                              5'd31, 5'd31, 4'd15, 7'd127), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_TIME_SYNC, 3'd6, 32'hDEAD_BEEF, 6'd0, 6'd0,
                              5'd0, 5'd0, 4'd0, 7'd0), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_TIME_SYNC, 3'd3, 32'h5555_AAAA, 6'd42, 6'd21,
                              5'd16, 5'd15, 4'd10, 7'd64), 1'b0);
    send_request(make_request(mrfb_pkg::CMD_READ, 3'd1, 32'hAAAA_5555, 6'd0, 6'd0,
                              5'd0, 5'd1, 4'd1, 7'd0), 1'b1);
    send_request(make_request(mrfb_pkg::CMD_TIME_SYNC, 3'd1, 32'h0000_0000, 6'd9, 6'd10,
                              5'd19, 5'd20, 4'd9, 7'd90), 1'b1);

    // Random phases under different meter addresses; the last has no idling.
    run_phase(48'hFFFF_FFFF_FFFF, 1'b1);
    run_phase(48'h0000_0000_0000, 1'b1);
    run_phase(48'({$urandom, $urandom}), 1'b1);
    run_phase(48'({$urandom, $urandom}), 1'b0);

    // Drain, then watch for stray bytes before deciding.
    start <= 1'b0;
    do @(posedge clk); while (frame_check.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_check.mismatches == 0 && frame_check.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mrfb_pkg.sv
rtl/core/mrfb_front.sv
rtl/core/mrfb_queue.sv
rtl/core/mrfb_back.sv
rtl/core/meter_request_frame_builder.sv
tb/meter_request_frame_builder_test.sv
